FILE: design/uft_pkg.sv
// ----------------------------------------------------------------------------
// uft_pkg
// Shared types, codes and helpers for the UART FIFO block with RTS/CTS
// flow control.
// ----------------------------------------------------------------------------
package uft_pkg;

  // Ring depth of each byte FIFO; one slot always stays free.
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  // Decoupling queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request command codes.
  localparam logic [2:0] CMD_HOST_WRITE = 3'd0;
  localparam logic [2:0] CMD_HOST_READ  = 3'd1;
  localparam logic [2:0] CMD_LINE_RX    = 3'd2;
  localparam logic [2:0] CMD_TX_READY   = 3'd3;
  localparam logic [2:0] CMD_CTS_EDGE   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_SENT     = 2'd1;
  localparam logic [1:0] KIND_RETURNED = 2'd2;
  localparam logic [1:0] KIND_REFUSED  = 2'd3;

  // Operations after classification by the front part.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WR_DIRECT,
    OP_WR_QUEUE,
    OP_HOST_RD,
    OP_LINE_RX,
    OP_TX_READY,
    OP_CTS_EDGE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_item_t;

  // Head of the decoupling queue as seen by the back part.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef enum logic {
    BK_EXEC,
    BK_RDATA
  } back_state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: design/uart_fifo_rts_cts_flow_control.sv
// ----------------------------------------------------------------------------
// uart_fifo_rts_cts_flow_control
// UART transmit and receive ring FIFOs with RTS/CTS flow-control state.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ------------------------------------
// in       request    in_valid / in_stall  cmd, data, line_tx_idle
// out      result     out_valid/out_stall  kind, byte_out, rts_high, send_enabled
//
// Every accepted request gives exactly one result. A request is classified by
// the front part and sits in a two-entry queue, then the back part executes
// it. Sustained rate is one request per cycle while results are not stalled;
// a host read that returns a byte or a transmitter-ready that sends one holds
// back the next request while the registered ring RAM read port delivers the byte.
// A result passes the queue entry, for a pop the RAM read register, and the
// output register. Reset is synchronous and empties both rings and the queue;
// RTS comes out high and sending enabled. A stalled result holds in the output
// register while the queue keeps taking requests until it is full.
//
// The transmitter is fed directly by a host write when it is idle, even if
// bytes are still queued. A received line byte raises RTS when only one free
// slot would remain, and is dropped when the receive ring is already full.
// Successive CTS edge requests alternately disable and re-enable sending.
// ----------------------------------------------------------------------------
module uart_fifo_rts_cts_flow_control (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] data,
  input  logic       line_tx_idle,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] byte_out,
  output logic       rts_high,
  output logic       send_enabled
);

  // Head of the decoupling queue, and the pop request back to it.
  uft_pkg::q_head_t q_head;
  logic             q_pop;

  uft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .data         (data),
    .line_tx_idle (line_tx_idle),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  uft_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .byte_out     (byte_out),
    .rts_high     (rts_high),
    .send_enabled (send_enabled)
  );

endmodule

FILE: design/uft_ram.sv
// ----------------------------------------------------------------------------
// uft_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module uft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/uft_front.sv
// ----------------------------------------------------------------------------
// uft_front
// Accepts requests, classifies them into operations and holds them in a
// short queue for the back part.
// ----------------------------------------------------------------------------
module uft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          cmd,
  input  logic [7:0]          data,
  input  logic                line_tx_idle,
  output uft_pkg::q_head_t    q_head,
  input  logic                q_pop
);

  uft_pkg::q_item_t                  entries [uft_pkg::QUEUE_DEPTH];
  logic [uft_pkg::QIDX_W-1:0]        head;
  logic [uft_pkg::QIDX_W-1:0]        head_next;
  logic [uft_pkg::QCNT_W-1:0]        count;
  logic [uft_pkg::QCNT_W-1:0]        count_next;
  logic [uft_pkg::QIDX_W-1:0]        wr_idx;
  logic                              push;
  uft_pkg::q_item_t                  classified;

  // A host write is resolved here: an idle transmitter takes the byte
  // directly, otherwise it is a queue push.
  always_comb begin
    classified.data = data;
    unique case (cmd)
      uft_pkg::CMD_HOST_WRITE: begin
        classified.op = line_tx_idle ? uft_pkg::OP_WR_DIRECT : uft_pkg::OP_WR_QUEUE;
      end
      uft_pkg::CMD_HOST_READ:  classified.op = uft_pkg::OP_HOST_RD;
      uft_pkg::CMD_LINE_RX:    classified.op = uft_pkg::OP_LINE_RX;
      uft_pkg::CMD_TX_READY:   classified.op = uft_pkg::OP_TX_READY;
      uft_pkg::CMD_CTS_EDGE:   classified.op = uft_pkg::OP_CTS_EDGE;
      default:                 classified.op = uft_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (count == uft_pkg::QCNT_W'(uft_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign wr_idx   = uft_pkg::QIDX_W'(head + count);

  assign q_head.valid = (count != '0);
  assign q_head.item  = entries[head];

  always_comb begin
    head_next  = head;
    count_next = count;
    if (q_pop && q_head.valid) begin
      head_next = (head == uft_pkg::QIDX_W'(uft_pkg::QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    end
    count_next = count + uft_pkg::QCNT_W'(push) - uft_pkg::QCNT_W'(q_pop && q_head.valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= classified;
    end
  end

endmodule

FILE: design/uft_back.sv
// ----------------------------------------------------------------------------
// uft_back
// Carries out classified operations on the transmit and receive rings,
// keeps the RTS/CTS state and drives the result register.
// ----------------------------------------------------------------------------
module uft_back (
  input  logic                clk,
  input  logic                rst,
  input  uft_pkg::q_head_t    q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          byte_out,
  output logic                rts_high,
  output logic                send_enabled
);

  localparam int PW = uft_pkg::PTR_W;

  uft_pkg::back_state_t state, state_next;
  logic [PW-1:0] tx_rd, tx_rd_next, tx_wr, tx_wr_next;
  logic [PW-1:0] rx_rd, rx_rd_next, rx_wr, rx_wr_next;
  logic          rts_level, rts_level_next;
  logic          sending_on, sending_on_next;
  logic          expect_rising, expect_rising_next;
  logic          pend_rx, pend_rx_next;

  logic          out_free;
  logic          out_load;
  logic [1:0]    load_kind;
  logic [7:0]    load_byte;

  logic          tx_we, tx_re, rx_we, rx_re;
  logic [7:0]    tx_rdata, rx_rdata;
  logic [PW-1:0] tx_wr_inc, rx_wr_inc, rx_wr_inc2, tx_rd_inc, rx_rd_inc;

  assign tx_wr_inc  = uft_pkg::ring_next(tx_wr);
  assign tx_rd_inc  = uft_pkg::ring_next(tx_rd);
  assign rx_wr_inc  = uft_pkg::ring_next(rx_wr);
  assign rx_wr_inc2 = uft_pkg::ring_next(rx_wr_inc);
  assign rx_rd_inc  = uft_pkg::ring_next(rx_rd);

  assign out_free = !out_valid || !out_stall;

  uft_ram #(.WIDTH(8), .DEPTH(uft_pkg::DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr),
    .wdata (q_head.item.data),
    .re    (tx_re),
    .raddr (tx_rd),
    .rdata (tx_rdata)
  );

  uft_ram #(.WIDTH(8), .DEPTH(uft_pkg::DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr),
    .wdata (q_head.item.data),
    .re    (rx_re),
    .raddr (rx_rd),
    .rdata (rx_rdata)
  );

  always_comb begin
    state_next         = state;
    tx_rd_next         = tx_rd;
    tx_wr_next         = tx_wr;
    rx_rd_next         = rx_rd;
    rx_wr_next         = rx_wr;
    rts_level_next     = rts_level;
    sending_on_next    = sending_on;
    expect_rising_next = expect_rising;
    pend_rx_next       = pend_rx;
    q_pop              = 1'b0;
    out_load           = 1'b0;
    load_kind          = uft_pkg::KIND_NONE;
    load_byte          = '0;
    tx_we              = 1'b0;
    tx_re              = 1'b0;
    rx_we              = 1'b0;
    rx_re              = 1'b0;

    unique case (state)
      uft_pkg::BK_EXEC: begin
        if (q_head.valid && out_free) begin
          q_pop    = 1'b1;
          out_load = 1'b1;
          unique case (q_head.item.op)
            uft_pkg::OP_WR_DIRECT: begin
              load_kind = uft_pkg::KIND_SENT;
              load_byte = q_head.item.data;
            end
            uft_pkg::OP_WR_QUEUE: begin
              if (tx_wr_inc == tx_rd) begin
                load_kind = uft_pkg::KIND_REFUSED;
              end else begin
                tx_we      = 1'b1;
                tx_wr_next = tx_wr_inc;
              end
            end
            uft_pkg::OP_HOST_RD: begin
              if (rx_rd == rx_wr) begin
                rts_level_next = 1'b0;
              end else begin
                rx_re        = 1'b1;
                rx_rd_next   = rx_rd_inc;
                pend_rx_next = 1'b1;
                out_load     = 1'b0;
                state_next   = uft_pkg::BK_RDATA;
              end
            end
            uft_pkg::OP_LINE_RX: begin
              if (rx_wr_inc2 == rx_rd) begin
                rts_level_next = 1'b1;
              end
              if (rx_wr_inc == rx_rd) begin
                load_kind = uft_pkg::KIND_REFUSED;
              end else begin
                rx_we      = 1'b1;
                rx_wr_next = rx_wr_inc;
              end
            end
            uft_pkg::OP_TX_READY: begin
              if (sending_on && (tx_rd != tx_wr)) begin
                tx_re        = 1'b1;
                tx_rd_next   = tx_rd_inc;
                pend_rx_next = 1'b0;
                out_load     = 1'b0;
                state_next   = uft_pkg::BK_RDATA;
              end
            end
            uft_pkg::OP_CTS_EDGE: begin
              sending_on_next    = expect_rising;
              expect_rising_next = !expect_rising;
            end
            default: begin
            end
          endcase
        end
      end
      uft_pkg::BK_RDATA: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_kind  = pend_rx ? uft_pkg::KIND_RETURNED : uft_pkg::KIND_SENT;
          load_byte  = pend_rx ? rx_rdata : tx_rdata;
          state_next = uft_pkg::BK_EXEC;
        end
      end
      default: begin
        state_next = uft_pkg::BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= uft_pkg::BK_EXEC;
      tx_rd         <= '0;
      tx_wr         <= '0;
      rx_rd         <= '0;
      rx_wr         <= '0;
      rts_level     <= 1'b1;
      sending_on    <= 1'b1;
      expect_rising <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      tx_rd         <= tx_rd_next;
      tx_wr         <= tx_wr_next;
      rx_rd         <= rx_rd_next;
      rx_wr         <= rx_wr_next;
      rts_level     <= rts_level_next;
      sending_on    <= sending_on_next;
      expect_rising <= expect_rising_next;
      out_valid     <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    pend_rx <= pend_rx_next;
    if (out_load) begin
      kind         <= load_kind;
      byte_out     <= load_byte;
      rts_high     <= rts_level_next;
      send_enabled <= sending_on_next;
    end
  end

`ifndef ASSERT_OFF
  // Sending is enabled exactly when a falling CTS edge is expected next.
  a_cts_phase: assert property (@(posedge clk) disable iff (rst)
    sending_on != expect_rising)
    else $error("CTS phase and sending flag disagree");

  // No operation leaves the queue while a ring read is outstanding.
  a_no_pop_in_rdata: assert property (@(posedge clk) disable iff (rst)
    (state == uft_pkg::BK_RDATA) |-> !q_pop)
    else $error("queue popped during ring read");

  // A queued host write never fills the last free slot of the transmit ring.
  a_tx_slot_free: assert property (@(posedge clk) disable iff (rst)
    (q_pop && tx_we) |=> (tx_wr != tx_rd))
    else $error("transmit ring overran its free slot");

  // RTS rises only because a byte arrived from the line.
  a_rts_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(rts_level) |-> $past(q_pop && (q_head.item.op == uft_pkg::OP_LINE_RX)))
    else $error("RTS raised without a received byte");
`endif

endmodule

FILE: sim/uart_fifo_rts_cts_flow_control_tb.sv
// ----------------------------------------------------------------------------
// uart_fifo_rts_cts_flow_control_tb
// Self-checking testbench for the UART FIFO block with RTS/CTS flow control.
// A queue of requests feeds a clocked driver. A clocked monitor compares every
// result with the prediction made when its request was accepted. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module uart_fifo_rts_cts_flow_control_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int RANDOM_ITEMS   = 650;
  // Once fewer requests than this are waiting, both sides stop idling.
  localparam int CALM_TAIL      = 60;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       line_tx_idle;
  } uart_request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       rts_high;
    logic       send_enabled;
  } uart_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] cmd = '0;
  logic [7:0] data = '0;
  logic       line_tx_idle = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic       rts_high;
  logic       send_enabled;

  uart_request_t request_queue[$];
  uart_result_t  expected_results[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;

  // Set with a nonblocking assignment so that both clocked blocks see the same
  // value at any given edge.
  logic calm = 1'b0;

  uart_fifo_rts_cts_flow_control uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .data         (data),
    .line_tx_idle (line_tx_idle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .byte_out     (byte_out),
    .rts_high     (rts_high),
    .send_enabled (send_enabled)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state. The rings are only ever read at slots that were written
  // earlier, so their initial contents do not matter.
  // --------------------------------------------------------------------------
  logic [7:0]                tx_ring [uft_pkg::DEPTH];
  logic [7:0]                rx_ring [uft_pkg::DEPTH];
  logic [uft_pkg::PTR_W-1:0] tx_head = '0;
  logic [uft_pkg::PTR_W-1:0] tx_tail = '0;
  logic [uft_pkg::PTR_W-1:0] rx_head = '0;
  logic [uft_pkg::PTR_W-1:0] rx_tail = '0;
  logic                      rts_level = 1'b1;
  logic                      sending_on = 1'b1;
  logic                      await_rising = 1'b0;

  // Moves a ring pointer on by a number of slots, wrapping at the ring depth.
  function automatic logic [uft_pkg::PTR_W-1:0] advance(
    input logic [uft_pkg::PTR_W-1:0] p,
    input int unsigned               steps
  );
    return uft_pkg::PTR_W'((int'(p) + steps) % uft_pkg::DEPTH);
  endfunction

  // Works out the result of one request and updates the predicted state.
  // Heads are read pointers and tails are write pointers.
  function automatic uart_result_t predict_uart_result(input uart_request_t r);
    uart_result_t res;
    res = '0;
    case (r.cmd)
      uft_pkg::CMD_HOST_WRITE: begin
        // An idle transmitter takes the byte directly, even with bytes queued.
        if (r.line_tx_idle) begin
          res.kind     = uft_pkg::KIND_SENT;
          res.byte_out = r.data;
        end else if (advance(tx_tail, 1) == tx_head) begin
          res.kind = uft_pkg::KIND_REFUSED;
        end else begin
          tx_ring[tx_tail] = r.data;
          tx_tail          = advance(tx_tail, 1);
        end
      end
      uft_pkg::CMD_HOST_READ: begin
        // An empty ring lets the peer send again; a pop leaves RTS alone.
        if (rx_head == rx_tail) begin
          rts_level = 1'b0;
        end else begin
          res.kind     = uft_pkg::KIND_RETURNED;
          res.byte_out = rx_ring[rx_head];
          rx_head      = advance(rx_head, 1);
        end
      end
      uft_pkg::CMD_LINE_RX: begin
        // RTS goes high when only one free slot would remain, and is checked
        // even when the byte itself is dropped.
        if (advance(rx_tail, 2) == rx_head) begin
          rts_level = 1'b1;
        end
        if (advance(rx_tail, 1) == rx_head) begin
          res.kind = uft_pkg::KIND_REFUSED;
        end else begin
          rx_ring[rx_tail] = r.data;
          rx_tail          = advance(rx_tail, 1);
        end
      end
      uft_pkg::CMD_TX_READY: begin
        if (sending_on && tx_head != tx_tail) begin
          res.kind     = uft_pkg::KIND_SENT;
          res.byte_out = tx_ring[tx_head];
          tx_head      = advance(tx_head, 1);
        end
      end
      uft_pkg::CMD_CTS_EDGE: begin
        // Edges alternate: falling disables sending, rising enables it again.
        if (await_rising) begin
          await_rising = 1'b0;
          sending_on   = 1'b1;
        end else begin
          sending_on   = 1'b0;
          await_rising = 1'b1;
        end
      end
      default: begin
        // Unused command codes leave everything as it was.
      end
    endcase
    res.rts_high     = rts_level;
    res.send_enabled = sending_on;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. A request that is presented stays unchanged until it is
  // accepted. Between requests the driver may idle for a burst of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    uart_request_t next_req;
    int unsigned   gap_left;
    logic          gaps_on;
    logic          free_slot;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      gaps_on  = 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_uart_result('{cmd, data, line_tx_idle}));
        // Now and then switch between idling and running flat out.
        if ($urandom_range(0, 39) == 0) begin
          gaps_on = ~gaps_on;
        end
      end
      free_slot = !in_valid || !in_stall;
      if (free_slot) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && gaps_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 16) - 1;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          next_req = request_queue.pop_front();
          in_valid     <= 1'b1;
          cmd          <= next_req.cmd;
          data         <= next_req.data;
          line_tx_idle <= next_req.line_tx_idle;
        end else begin
          in_valid <= 1'b0;
        end
      end
      calm <= (request_queue.size() < CALM_TAIL);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. It checks each accepted result against the oldest
  // prediction and drives the stall in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    uart_result_t want;
    int unsigned  stall_left;
    logic         stalls_on;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      stalls_on  = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d byte_out 0x%02h", kind, byte_out);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            error_count++;
          end
          if (byte_out !== want.byte_out) begin
            $error("byte_out: expected 0x%02h, got 0x%02h", want.byte_out, byte_out);
            error_count++;
          end
          if (rts_high !== want.rts_high) begin
            $error("rts_high: expected %0d, got %0d", want.rts_high, rts_high);
            error_count++;
          end
          if (send_enabled !== want.send_enabled) begin
            $error("send_enabled: expected %0d, got %0d", want.send_enabled,
                   send_enabled);
            error_count++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        stalls_on = ~stalls_on;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // A run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_request(input logic [2:0] c, input logic [7:0] d,
                             input logic idle);
    request_queue.push_back('{c, d, idle});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned counted;
    int unsigned burst;
    logic [2:0]  c;

    // Directed requests: reads and writes at the byte extremes, a direct
    // write while bytes are queued, transmitter-ready with sending disabled
    // and with an empty queue, and the unused command codes.
    add_request(uft_pkg::CMD_HOST_READ,  8'h00, 1'b0); // empty ring lowers RTS
    add_request(uft_pkg::CMD_HOST_WRITE, 8'h00, 1'b1);
    add_request(uft_pkg::CMD_HOST_WRITE, 8'hFF, 1'b1);
    add_request(uft_pkg::CMD_HOST_WRITE, 8'hA5, 1'b0);
    add_request(uft_pkg::CMD_HOST_WRITE, 8'h5A, 1'b0);
    add_request(uft_pkg::CMD_CTS_EDGE,   8'h00, 1'b0); // sending off
    add_request(uft_pkg::CMD_TX_READY,   8'h00, 1'b0); // nothing is sent
    add_request(uft_pkg::CMD_HOST_WRITE, 8'h3C, 1'b1); // bypasses the queued bytes
    add_request(uft_pkg::CMD_CTS_EDGE,   8'hFF, 1'b1); // sending on again
    add_request(uft_pkg::CMD_TX_READY,   8'hFF, 1'b1);
    add_request(uft_pkg::CMD_TX_READY,   8'h00, 1'b0);
    add_request(uft_pkg::CMD_TX_READY,   8'h00, 1'b0); // queue now empty
    add_request(uft_pkg::CMD_LINE_RX,    8'hFF, 1'b0);
    add_request(uft_pkg::CMD_LINE_RX,    8'h00, 1'b1);
    add_request(uft_pkg::CMD_HOST_READ,  8'h00, 1'b0); // pop leaves RTS unchanged
    add_request(uft_pkg::CMD_HOST_READ,  8'hFF, 1'b1);
    add_request(uft_pkg::CMD_HOST_READ,  8'h00, 1'b0);
    add_request(3'd5,                    8'h81, 1'b1);
    add_request(3'd6,                    8'h7E, 1'b0);
    add_request(3'd7,                    8'hFF, 1'b1);

    // Random part, built from runs that fill and drain each ring past full and
    // empty, CTS edge requests, and unstructured noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          burst = $urandom_range(10, 20);
          repeat (burst) add_request(uft_pkg::CMD_LINE_RX, 8'($urandom), 1'($urandom));
          counted += burst;
        end
        2, 3: begin
          burst = $urandom_range(5, 18);
          repeat (burst) add_request(uft_pkg::CMD_HOST_READ, 8'($urandom), 1'($urandom));
          counted += burst;
        end
        4, 5: begin
          burst = $urandom_range(8, 20);
          repeat (burst) begin
            add_request(uft_pkg::CMD_HOST_WRITE, 8'($urandom),
                        $urandom_range(0, 7) == 0);
          end
          counted += burst;
        end
        6: begin
          burst = $urandom_range(4, 18);
          repeat (burst) begin
            if ($urandom_range(0, 5) == 0) begin
              add_request(uft_pkg::CMD_CTS_EDGE, 8'($urandom), 1'($urandom));
            end else begin
              add_request(uft_pkg::CMD_TX_READY, 8'($urandom), 1'($urandom));
            end
          end
          counted += burst;
        end
        7: begin
          burst = $urandom_range(1, 2);
          repeat (burst) add_request(uft_pkg::CMD_CTS_EDGE, 8'($urandom), 1'($urandom));
          counted += burst;
        end
        default: begin
          burst = $urandom_range(4, 12);
          repeat (burst) begin
            c = 3'($urandom_range(0, 7));
            add_request(c, 8'($urandom), 1'($urandom));
            if (c <= uft_pkg::CMD_CTS_EDGE) begin
              counted++;
            end
          end
        end
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every result to come out, then
    // run on for DRAIN_CYCLES so that any stray result would show.
    while (request_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/uft_pkg.sv
design/uft_ram.sv
design/uft_front.sv
design/uft_back.sv
design/uart_fifo_rts_cts_flow_control.sv
sim/uart_fifo_rts_cts_flow_control_tb.sv
